>>> rtl/dtgd_pkg.sv
// shared types and constants for the double-tap gesture detector
// no dependencies
`default_nettype none
package dtgd_pkg;
    localparam int PRESS_SLOTS = 10;
    localparam int TAP_SLOTS = 8;
    localparam int PC_W = $clog2(PRESS_SLOTS + 1);
    localparam int TC_W = $clog2(TAP_SLOTS + 1);

    localparam logic [2:0] OP_PRESS = 3'd0;
    localparam logic [2:0] OP_REL = 3'd1;
    localparam logic [2:0] OP_FINAL = 3'd2;
    localparam logic [2:0] OP_CANCEL = 3'd3;
    localparam logic [2:0] OP_MOVE = 3'd4;

    localparam logic [1:0] REG_TAP_TO = 2'd0;
    localparam logic [1:0] REG_DTAP_TO = 2'd1;
    localparam logic [1:0] REG_TAP_SLOP = 2'd2;
    localparam logic [1:0] REG_DTAP_SLOP = 2'd3;

    // one press entry
    typedef struct packed {
        logic        valid;
        logic [4:0]  id;
        logic [31:0] tstamp;
        logic [31:0] pos;
    } press_t;

    // one tap entry
    typedef struct packed {
        logic        valid;
        logic [31:0] tstamp;
        logic [31:0] pos;
    } tap_t;

    // squared distance compare, exact: sum of squares fits 33 bits
    function automatic logic in_reach(input logic [31:0] pa, input logic [31:0] pb,
                                      input logic [15:0] slop);
        logic [15:0] dx;
        logic [15:0] dy;
        logic [31:0] dx2;
        logic [31:0] dy2;
        logic [32:0] d;
        begin
            dx = (pa[15:0] > pb[15:0]) ? pa[15:0] - pb[15:0] : pb[15:0] - pa[15:0];
            dy = (pa[31:16] > pb[31:16]) ? pa[31:16] - pb[31:16] : pb[31:16] - pa[31:16];
            dx2 = 32'(dx) * 32'(dx);
            dy2 = 32'(dy) * 32'(dy);
            d = 33'(dx2) + 33'(dy2);
            in_reach = d <= 33'(32'(slop) * 32'(slop));
        end
    endfunction
endpackage
`default_nettype wire

>>> rtl/dtgd_press_cell.sv
// one press slot of the press chain, shifts toward slot 0 on removal
// depends on dtgd_pkg
`default_nettype none
module dtgd_press_cell import dtgd_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   clear,
    input  wire logic   load,
    input  wire press_t load_val,
    input  wire logic   shift,
    input  wire press_t right_val,
    output press_t      ent
);
    press_t ent_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            ent_reg.valid <= 1'b0;
        end else if (load) begin
            ent_reg <= load_val;
        end else if (shift) begin
            ent_reg <= right_val;
        end
    end
    assign ent = ent_reg;
endmodule
`default_nettype wire

>>> rtl/dtgd_tap_cell.sv
// one tap slot of the tap ring; the ring rotates one slot a cycle during a walk, unless the walk pauses
// depends on dtgd_pkg
`default_nettype none
module dtgd_tap_cell import dtgd_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic load,
    input  wire tap_t load_val,
    input  wire logic rot,
    input  wire tap_t right_val,
    output tap_t      ent
);
    tap_t ent_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg.valid <= 1'b0;
        end else if (load) begin
            ent_reg <= load_val;
        end else if (rot) begin
            ent_reg <= right_val;
        end
    end
    assign ent = ent_reg;
endmodule
`default_nettype wire

>>> rtl/double_tap_gesture_detector.sv
// double-tap gesture detector top level: press chain, tap ring and sequencer
// depends on dtgd_pkg, dtgd_press_cell, dtgd_tap_cell
`default_nettype none
// After a press is taken, ready stays low while the stored taps pass through
// slot 0 one per cycle, oldest first, unless the walk pauses; each is aged and
// compared, and a kept tap re-enters at the tail of the valid run, so the
// run stays packed and in order. Each hit is sent as a transfer through a
// one-deep output register; the walk pauses while a hit waits for room, so a
// stalled receiver adds cycles. A release walks the press chain from slot 0,
// one slot a cycle; cancel and ignored ops leave the sequencer idle, so ready
// stays high.
module double_tap_gesture_detector import dtgd_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,  // op, pointer_id, time_stamp, pos_x, pos_y
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,  // hit_x, hit_y
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TAPS = 2'd1;
    localparam logic [1:0] ST_REL = 2'd2;
    localparam logic [1:0] ST_STORE = 2'd3;

    localparam tap_t TAP_EMPTY = '{valid: 1'b0, tstamp: '0, pos: '0};

    logic [31:0] tap_to_reg, dtap_to_reg;
    logic [15:0] tap_slop_reg, dtap_slop_reg;
    logic [1:0]  state_reg;
    logic [2:0]  op_reg;
    logic [4:0]  id_reg;
    logic [31:0] now_reg, pos_reg;
    logic [TC_W-1:0] rem_reg;
    logic [PC_W-1:0] pidx_reg;
    logic        pend_reg;    // a hit waits to find out if it is the last
    logic        found_reg;
    logic [31:0] f_time_reg, f_pos_reg;
    logic        ovalid_reg, olast_reg;
    logic [31:0] odata_reg;

    press_t pent [PRESS_SLOTS];
    tap_t   tent [TAP_SLOTS];
    logic   pclear, pload;
    logic [PRESS_SLOTS-1:0] pload_v, pshift_v;
    press_t pnew;
    logic   trot, tstore;
    tap_t   t0_next;
    logic [PC_W-1:0] pcount;
    logic [TC_W-1:0] tcount;

    logic accept;
    logic out_free;
    logic hit_now, keep_now, walk_go;
    logic ok_tap;
    logic emit, emit_last;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept = s_tvalid && s_tready;
    assign out_free = !ovalid_reg || m_tready;

    always_comb begin
        pcount = '0;
        for (int i = 0; i < PRESS_SLOTS; i++) begin
            if (pent[i].valid) pcount = PC_W'(i + 1);
        end
        tcount = '0;
        for (int i = 0; i < TAP_SLOTS; i++) begin
            if (tent[i].valid) tcount = TC_W'(i + 1);
        end
    end

    // tap walk: slot 0 is examined, the rest move down and a kept tap goes to
    // the tail of the valid run
    assign hit_now = tent[0].valid && ((now_reg - tent[0].tstamp) <= dtap_to_reg)
                     && in_reach(pos_reg, tent[0].pos, dtap_slop_reg);
    assign keep_now = tent[0].valid && ((now_reg - tent[0].tstamp) <= dtap_to_reg)
                      && !hit_now;
    // a hit needs room to emit the previously pending hit
    assign walk_go = (state_reg == ST_TAPS) && (rem_reg != '0)
                     && (!hit_now || !pend_reg || out_free);
    assign trot = walk_go;
    assign tstore = (state_reg == ST_STORE) && ok_tap && (tcount < TC_W'(TAP_SLOTS));

    assign emit = (walk_go && hit_now && pend_reg)
                  || ((state_reg == ST_STORE) && pend_reg && out_free);
    assign emit_last = (state_reg == ST_STORE);

    always_comb begin
        t0_next = tent[0];
        t0_next.valid = keep_now;
    end

    assign ok_tap = found_reg && ((now_reg - f_time_reg) <= tap_to_reg)
                    && in_reach(f_pos_reg, pos_reg, tap_slop_reg);

    // press chain control
    logic pmatch;
    assign pmatch = (state_reg == ST_REL) && !found_reg
                    && (pidx_reg < pcount) && (pent[pidx_reg].id == id_reg);
    assign pnew = '{valid: 1'b1, id: s_tdata[7:3], tstamp: s_tdata[39:8],
                    pos: s_tdata[71:40]};
    assign pload = accept && (s_tdata[2:0] == OP_PRESS) && (pcount < PC_W'(PRESS_SLOTS));
    assign pclear = (accept && (s_tdata[2:0] == OP_CANCEL))
                    || (state_reg == ST_STORE && op_reg == OP_FINAL);
    always_comb begin
        for (int i = 0; i < PRESS_SLOTS; i++) begin
            pload_v[i] = pload && (PC_W'(i) == pcount);
            // once the match is found, slots from it onward pull from the right
            pshift_v[i] = (state_reg == ST_REL) && (found_reg || pmatch)
                          && (PC_W'(i) == pidx_reg);
        end
    end

    genvar g;
    generate
        for (g = 0; g < PRESS_SLOTS; g++) begin : g_press
            press_t rv;
            if (g == PRESS_SLOTS - 1) begin : g_end
                assign rv = '{valid: 1'b0, id: '0, tstamp: '0, pos: '0};
            end else begin : g_mid
                assign rv = pent[g+1];
            end
            dtgd_press_cell u_cell (
                .aclk(aclk), .aresetn(aresetn), .clear(pclear),
                .load(pload_v[g]), .load_val(pnew),
                .shift(pshift_v[g]), .right_val(rv), .ent(pent[g])
            );
        end
        for (g = 0; g < TAP_SLOTS; g++) begin : g_tap
            tap_t rv;
            logic ld;
            tap_t lv;
            if (g == TAP_SLOTS - 1) begin : g_end
                assign rv = (TC_W'(g + 1) == tcount) ? t0_next : TAP_EMPTY;
            end else begin : g_mid
                assign rv = (TC_W'(g + 1) == tcount) ? t0_next : tent[g+1];
            end
            assign ld = tstore && (TC_W'(g) == tcount);
            assign lv = '{valid: 1'b1, tstamp: f_time_reg, pos: pos_reg};
            dtgd_tap_cell u_cell (
                .aclk(aclk), .aresetn(aresetn), .load(ld), .load_val(lv),
                .rot(trot), .right_val(rv), .ent(tent[g])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_to_reg <= '0;
            dtap_to_reg <= '0;
            tap_slop_reg <= '0;
            dtap_slop_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TAP_TO:    tap_to_reg <= cfg_data;
                REG_DTAP_TO:   dtap_to_reg <= cfg_data;
                REG_TAP_SLOP:  tap_slop_reg <= cfg_data[15:0];
                REG_DTAP_SLOP: dtap_slop_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (emit) begin
            ovalid_reg <= 1'b1;
            olast_reg <= emit_last;
            odata_reg <= pos_reg;
        end else if (m_tready) begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        op_reg <= s_tdata[2:0];
                        id_reg <= s_tdata[7:3];
                        now_reg <= s_tdata[39:8];
                        pos_reg <= s_tdata[71:40];
                        rem_reg <= tcount;
                        pidx_reg <= '0;
                        found_reg <= 1'b0;
                        pend_reg <= 1'b0;
                        if (s_tdata[2:0] == OP_PRESS) state_reg <= ST_TAPS;
                        else if (s_tdata[2:0] == OP_REL || s_tdata[2:0] == OP_FINAL)
                            state_reg <= ST_REL;
                    end
                end
                ST_TAPS: begin
                    if (rem_reg == '0) begin
                        state_reg <= ST_STORE;
                    end else if (walk_go) begin
                        rem_reg <= rem_reg - 1'b1;
                        if (hit_now) pend_reg <= 1'b1;
                        if (rem_reg == TC_W'(1)) state_reg <= ST_STORE;
                    end
                end
                ST_REL: begin
                    if (pmatch) begin
                        found_reg <= 1'b1;
                        f_time_reg <= pent[pidx_reg].tstamp;
                        f_pos_reg <= pent[pidx_reg].pos;
                    end
                    if (pidx_reg >= pcount || pidx_reg == PC_W'(PRESS_SLOTS - 1))
                        state_reg <= ST_STORE;
                    else pidx_reg <= pidx_reg + 1'b1;
                end
                ST_STORE: begin
                    // every walk ends here: a press flushes its last pending hit, a release may store its tap
                    if (!pend_reg) state_reg <= ST_IDLE;
                    else if (out_free) begin
                        pend_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata = odata_reg;
    assign m_tlast = olast_reg;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pend_reg) else $error("pending hit while idle");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("output changed");
    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |=> !(state_reg == ST_STORE)) else $error("skipped walk");
endmodule
`default_nettype wire

>>> test/testbench.sv
// testbench for the double-tap gesture detector: touch events in, double-tap hits out
// predicts every hit with its own press/tap tables; depends on dtgd_pkg and the rtl
`timescale 1ns / 1ps
module testbench;
    import dtgd_pkg::*;

    typedef struct packed {
        logic [15:0] y;
        logic [15:0] x;
        logic        last;
    } hit_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    double_tap_gesture_detector i_dut (.*);

    initial forever #5 aclk = ~aclk;

    // predictor state
    logic [31:0] tap_to, dtap_to;
    logic [15:0] tap_slp, dtap_slp;
    int          n_press, n_tap;
    logic [4:0]  pr_id[PRESS_SLOTS];
    logic [31:0] pr_time[PRESS_SLOTS], pr_pos[PRESS_SLOTS];
    logic [31:0] tp_time[TAP_SLOTS], tp_pos[TAP_SLOTS];

    hit_t        expected_hits[$];
    int          errors = 0;
    int          gap_mode = 0;    // 0 random bursts, 1 no gaps
    int          stall_mode = 0;
    logic [31:0] clock_now = 32'd1000;

    function automatic bit close_enough(logic [31:0] a, logic [31:0] b, logic [15:0] s);
        longint dx, dy;
        dx = longint'(a[15:0]) - longint'(b[15:0]);
        dy = longint'(a[31:16]) - longint'(b[31:16]);
        return dx * dx + dy * dy <= longint'(s) * longint'(s);
    endfunction

    task automatic predict_event(logic [2:0] op, logic [4:0] id, logic [31:0] now,
                                 logic [15:0] x, logic [15:0] y);
        logic [31:0] pos, t0, p0;
        int          w, k, first;
        hit_t        h;
        pos = {y, x};
        first = expected_hits.size();
        if (op == OP_PRESS) begin
            if (n_press < PRESS_SLOTS) begin
                pr_id[n_press] = id; pr_time[n_press] = now; pr_pos[n_press] = pos;
                n_press++;
            end
            w = 0;
            for (int i = 0; i < n_tap; i++) begin
                if (now - tp_time[i] > dtap_to) continue;
                if (close_enough(pos, tp_pos[i], dtap_slp)) begin
                    h.x = x; h.y = y; h.last = 0;
                    expected_hits = {expected_hits, h};
                    continue;
                end
                tp_time[w] = tp_time[i]; tp_pos[w] = tp_pos[i]; w++;
            end
            n_tap = w;
            if (expected_hits.size() > first)
                expected_hits[expected_hits.size() - 1].last = 1;
        end else if (op == OP_REL || op == OP_FINAL) begin
            k = -1;
            for (int i = 0; i < n_press; i++)
                if (k < 0 && pr_id[i] == id) k = i;
            if (k >= 0) begin
                t0 = pr_time[k]; p0 = pr_pos[k];
                for (int i = k; i + 1 < n_press; i++) begin
                    pr_id[i] = pr_id[i+1]; pr_time[i] = pr_time[i+1]; pr_pos[i] = pr_pos[i+1];
                end
                n_press--;
                if (now - t0 <= tap_to && close_enough(p0, pos, tap_slp) && n_tap < TAP_SLOTS) begin
                    tp_time[n_tap] = t0; tp_pos[n_tap] = pos; n_tap++;
                end
            end
            if (op == OP_FINAL) n_press = 0;
        end else if (op == OP_CANCEL) begin
            n_press = 0;
        end
    endtask

    // valid stays high after a transfer until the next item or a gap replaces it
    task automatic send_event(logic [2:0] op, logic [4:0] id, logic [31:0] now,
                              logic [15:0] x, logic [15:0] y);
        if (gap_mode == 0 && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        predict_event(op, id, now, x, y);
        s_tdata <= {y, x, now, id, op};
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 0;
        while (expected_hits.size() != 0) @(negedge aclk);
        // a release or a miss has no result; let the sequencer finish
        repeat (4 * (TAP_SLOTS + PRESS_SLOTS + 4)) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 0;
        @(negedge aclk);
        case (idx)
            REG_TAP_TO:    tap_to = val;
            REG_DTAP_TO:   dtap_to = val;
            REG_TAP_SLOP:  tap_slp = val[15:0];
            REG_DTAP_SLOP: dtap_slp = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_all(logic [31:0] tt, logic [31:0] dt, logic [15:0] ts, logic [15:0] ds);
        wait_idle();
        write_reg(REG_TAP_TO, tt);
        write_reg(REG_DTAP_TO, dt);
        write_reg(REG_TAP_SLOP, {16'd0, ts});
        write_reg(REG_DTAP_SLOP, {16'd0, ds});
    endtask

    // checker on accepted hits
    always @(posedge aclk) begin
        hit_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_hits.size() == 0) begin
                $error("unexpected hit x=%0d y=%0d", m_tdata[15:0], m_tdata[31:16]);
                errors++;
            end else begin
                e = expected_hits.pop_front();
                if (m_tdata[15:0] !== e.x) begin
                    $error("hit_x expected %0d got %0d", e.x, m_tdata[15:0]); errors++;
                end
                if (m_tdata[31:16] !== e.y) begin
                    $error("hit_y expected %0d got %0d", e.y, m_tdata[31:16]); errors++;
                end
                if (m_tlast !== e.last) begin
                    $error("last_hit expected %0d got %0d", e.last, m_tlast); errors++;
                end
            end
        end
    end

    // receiver stall pattern
    always @(negedge aclk) begin
        case (stall_mode)
            0: m_tready <= ($urandom_range(0, 2) != 0);
            1: m_tready <= 1;
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic test_directed();
        set_all(32'd100, 32'd500, 16'd32, 16'd64);
        // double tap at the same spot
        send_event(OP_PRESS, 5'd1, 32'd10, 16'd100, 16'd200);
        send_event(OP_FINAL, 5'd1, 32'd50, 16'd110, 16'd200);
        send_event(OP_PRESS, 5'd1, 32'd200, 16'd120, 16'd210);
        send_event(OP_FINAL, 5'd1, 32'd230, 16'd120, 16'd210);
        // release without press, secondary release, cancel, ignored ops
        send_event(OP_REL, 5'd31, 32'd240, 16'hFFFF, 16'hFFFF);
        send_event(OP_PRESS, 5'd2, 32'd0, 16'hFFFF, 16'hFFFF);
        send_event(OP_PRESS, 5'd2, 32'd5, 16'hFFF0, 16'hFFFF);
        send_event(OP_REL, 5'd2, 32'd20, 16'hFFFF, 16'hFFFF);
        send_event(OP_CANCEL, 5'd0, 32'd30, 16'd0, 16'd0);
        send_event(OP_MOVE, 5'd3, 32'd31, 16'd1, 16'd1);
        send_event(3'd7, 5'd3, 32'd32, 16'd1, 16'd1);
        // too slow a tap, moved too far
        send_event(OP_PRESS, 5'd4, 32'hFFFF_FFF0, 16'd0, 16'd0);
        send_event(OP_FINAL, 5'd4, 32'd200, 16'd0, 16'd0);
        send_event(OP_PRESS, 5'd4, 32'd300, 16'd0, 16'd0);
        send_event(OP_FINAL, 5'd4, 32'd310, 16'd40, 16'd0);
        // wrapping timestamps: tap straddles zero then a press hits it
        send_event(OP_PRESS, 5'd6, 32'hFFFF_FFF8, 16'd500, 16'd500);
        send_event(OP_FINAL, 5'd6, 32'd4, 16'd500, 16'd500);
        send_event(OP_PRESS, 5'd6, 32'd40, 16'd500, 16'd500);
        send_event(OP_CANCEL, 5'd6, 32'd41, 16'd0, 16'd0);
    endtask

    // fill the tap table, then one press takes out every tap
    task automatic test_full_tables();
        set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < PRESS_SLOTS + 2; i++)
            send_event(OP_PRESS, 5'(i), 32'(i), 16'(i * 3), 16'(i));
        for (int i = PRESS_SLOTS + 1; i >= 0; i--)
            send_event(OP_REL, 5'(i), 32'(100 + i), 16'(i * 3), 16'(i));
        send_event(OP_PRESS, 5'd9, 32'd200, 16'hFFFF, 16'd0);
        send_event(OP_CANCEL, 5'd0, 32'd201, 16'd0, 16'd0);
        set_all(32'd0, 32'd0, 16'd0, 16'd0);
        send_event(OP_PRESS, 5'd1, 32'd7, 16'd9, 16'd9);
        send_event(OP_FINAL, 5'd1, 32'd7, 16'd9, 16'd9);
        send_event(OP_PRESS, 5'd1, 32'd7, 16'd9, 16'd9);
        send_event(OP_CANCEL, 5'd1, 32'd7, 16'd9, 16'd9);
    endtask

    task automatic random_gesture();
        logic [4:0]  id;
        logic [15:0] x, y;
        int          r;
        id = 5'($urandom_range(0, 31));
        x = 16'($urandom); y = 16'($urandom);
        r = $urandom_range(0, 9);
        if (r < 7) begin
            clock_now += $urandom_range(0, 300);
            send_event(OP_PRESS, id, clock_now, x, y);
            if ($urandom_range(0, 1)) begin
                clock_now += $urandom_range(0, 150);
                send_event(OP_PRESS, id ^ 5'd1, clock_now, x + 16'($urandom_range(0, 20)), y);
            end
            clock_now += $urandom_range(0, 160);
            send_event($urandom_range(0, 1) ? OP_FINAL : OP_REL, id, clock_now,
                       x + 16'($urandom_range(0, 40)), y - 16'($urandom_range(0, 40)));
        end else if (r == 7) begin
            send_event(OP_CANCEL, id, 32'($urandom), x, y);
        end else begin
            send_event(3'($urandom), id, 32'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic test_random(int count, logic [31:0] tt, logic [31:0] dt,
                               logic [15:0] ts, logic [15:0] ds);
        set_all(tt, dt, ts, ds);
        for (int i = 0; i < count; i++) begin
            random_gesture();
            if (i % 40 == 39) begin
                gap_mode = $urandom_range(0, 1);
                stall_mode = $urandom_range(0, 2);
            end
        end
    endtask

    initial begin
        tap_to = 0; dtap_to = 0; tap_slp = 0; dtap_slp = 0;
        n_press = 0; n_tap = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        test_directed();
        test_full_tables();
        test_random(60, 32'd120, 32'd600, 16'd48, 16'd96);
        test_random(40, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'd200);
        test_random(60, 32'd200, 32'd2000, 16'd64, 16'hFFFF);
        test_random(20, 32'd0, 32'd0, 16'd0, 16'd0);
        wait_idle();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule

>>> double_tap_gesture_detector.f
rtl/dtgd_pkg.sv
rtl/dtgd_press_cell.sv
rtl/dtgd_tap_cell.sv
rtl/double_tap_gesture_detector.sv
test/testbench.sv
